@@ design/bc1is_pkg.sv @@
// ----------------------------------------------------------------------------
// bc1is_pkg: shared types and constants for the BC1 index selector
// Field widths, queue depths and the request/result structs.
// ----------------------------------------------------------------------------
package bc1is_pkg;

  localparam int unsigned ItemDepthDefault   = 4;
  localparam int unsigned ResultDepthDefault = 2;

  localparam int unsigned PosW      = 4;
  localparam int unsigned IndexW    = 32;
  localparam int unsigned ErrW      = 22;
  localparam int unsigned EntryErrW = 18;  // four squares of 8-bit differences
  localparam int unsigned SqW       = 16;

  localparam logic [PosW-1:0] FirstPos = 4'd0;
  localparam logic [PosW-1:0] LastPos  = 4'd15;

  // One pixel request, palette attached so blocks can overlap in the back end
  typedef struct packed {
    logic [PosW-1:0]        pos;
    logic                   alpha_mode;
    logic [3:0][7:0]        pixel;    // [0]=R [1]=G [2]=B [3]=A
    logic [3:0][31:0]       palette;  // entry bytes: R, G, B, A from LSB
  } item_t;

  typedef struct packed {
    logic [IndexW-1:0] index_word;
    logic [ErrW-1:0]   block_error;
  } result_t;

endpackage

@@ design/bc1_index_selector.sv @@
// ----------------------------------------------------------------------------
// bc1_index_selector: BC1 palette index selection for one 4x4 block
// Decodes the two 5-6-5 endpoints into a four-entry palette, picks the
// nearest entry for each of 16 pixels and reports indices and total error.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake        payload
//  -------   ---------  ---------------  -----------------------------------
//  pixel     in         push_i / full_o  endpoint_word_i, pixel_*_i
//  result    out        pop_i / empty_o  index_word_o, block_error_o
//  config    in         cfg_we_i         cfg_wdata_i (alpha mode)
//
//  One pixel request per cycle sustained; full_o rises only when the
//  back end is held by a full result queue.
//  A block's result reaches the result ports after its 16th pixel is
//  accepted, through the pixel queue, three compare stages and result queue.
//  Reset clears the pixel position, alpha mode, queues and accumulators.
//  A full result queue stalls only the back end; the pixel queue keeps
//  taking requests until it fills.
//
module bc1_index_selector
  import bc1is_pkg::*;
#(
  parameter int unsigned ItemDepth   = ItemDepthDefault,
  parameter int unsigned ResultDepth = ResultDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel requests
  input  logic        push_i,
  output logic        full_o,
  input  logic [31:0] endpoint_word_i,
  input  logic [7:0]  pixel_red_i,
  input  logic [7:0]  pixel_green_i,
  input  logic [7:0]  pixel_blue_i,
  input  logic [7:0]  pixel_alpha_i,
  // results
  output logic        empty_o,
  input  logic        pop_i,
  output logic [31:0] index_word_o,
  output logic [21:0] block_error_o,
  // alpha mode register
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);

  // front to back: tagged pixel requests
  logic    item_push, item_full, item_pop, item_empty;
  item_t   item_in, item_out;
  // back to output: finished blocks
  logic    res_push, res_full;
  result_t res_in, res_out;

  bc1is_front u_front (
    .clk_i,
    .rst_ni,
    .push_i,
    .endpoint_word_i,
    .pixel_red_i,
    .pixel_green_i,
    .pixel_blue_i,
    .pixel_alpha_i,
    .cfg_we_i,
    .cfg_wdata_i,
    .q_full_i (item_full),
    .q_push_o (item_push),
    .q_item_o (item_in)
  );

  assign full_o = item_full;

  bc1is_fifo #(
    .Width ($bits(item_t)),
    .Depth (ItemDepth)
  ) u_item_q (
    .clk_i,
    .rst_ni,
    .push_i  (item_push),
    .wdata_i (item_in),
    .full_o  (item_full),
    .pop_i   (item_pop),
    .rdata_o (item_out),
    .empty_o (item_empty)
  );

  bc1is_back u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i  (item_empty),
    .q_item_i   (item_out),
    .q_pop_o    (item_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // output queue parts the back end from the result consumer
  bc1is_fifo #(
    .Width ($bits(result_t)),
    .Depth (ResultDepth)
  ) u_res_q (
    .clk_i,
    .rst_ni,
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i,
    .rdata_o (res_out),
    .empty_o
  );

  assign index_word_o  = res_out.index_word;
  assign block_error_o = res_out.block_error;

endmodule

@@ design/bc1is_fifo.sv @@
// ----------------------------------------------------------------------------
// bc1is_fifo: small synchronous queue
// Register-array queue with a fill count; push is refused only when full.
// ----------------------------------------------------------------------------
module bc1is_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ design/bc1is_front.sv @@
// ----------------------------------------------------------------------------
// bc1is_front: pixel intake and palette decode
// Tracks the pixel position, decodes the endpoint word on the first pixel
// and tags each pixel with its palette and the current alpha mode.
// ----------------------------------------------------------------------------
module bc1is_front
  import bc1is_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [31:0] endpoint_word_i,
  input  logic [7:0]  pixel_red_i,
  input  logic [7:0]  pixel_green_i,
  input  logic [7:0]  pixel_blue_i,
  input  logic [7:0]  pixel_alpha_i,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output item_t       q_item_o
);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [3:0][31:0] pal_q, pal_new;
  logic             alpha_q;
  logic             accept;

  function automatic logic [31:0] pack_entry(logic [7:0] r, logic [7:0] g,
                                             logic [7:0] b, logic [7:0] a);
    return {a, b, g, r};
  endfunction

  // floor(x/3) for x < 768: multiply by 683, drop 11 bits
  function automatic logic [7:0] div3(logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  always_comb begin
    logic [7:0] r0, g0, b0, r1, g1, b1;
    logic [8:0] sr, sg, sb;
    r0 = {endpoint_word_i[15:11], 3'b000};
    g0 = {endpoint_word_i[10:5], 2'b00};
    b0 = {endpoint_word_i[4:0], 3'b000};
    r1 = {endpoint_word_i[31:27], 3'b000};
    g1 = {endpoint_word_i[26:21], 2'b00};
    b1 = {endpoint_word_i[20:16], 3'b000};
    sr = {1'b0, r0} + {1'b0, r1};
    sg = {1'b0, g0} + {1'b0, g1};
    sb = {1'b0, b0} + {1'b0, b1};
    pal_new[0] = pack_entry(r0, g0, b0, 8'hFF);
    pal_new[1] = pack_entry(r1, g1, b1, 8'hFF);
    if (endpoint_word_i[15:0] > endpoint_word_i[31:16]) begin
      pal_new[2] = pack_entry(div3({1'b0, sr} + {2'b00, r0}),
                              div3({1'b0, sg} + {2'b00, g0}),
                              div3({1'b0, sb} + {2'b00, b0}), 8'hFF);
      pal_new[3] = pack_entry(div3({1'b0, sr} + {2'b00, r1}),
                              div3({1'b0, sg} + {2'b00, g1}),
                              div3({1'b0, sb} + {2'b00, b1}), 8'hFF);
    end else begin
      pal_new[2] = pack_entry(sr[8:1], sg[8:1], sb[8:1], 8'hFF);
      pal_new[3] = '0;  // transparent black
    end
  end

  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;
  assign pos_d    = (pos_q == LastPos) ? FirstPos : pos_q + 1'b1;

  always_comb begin
    q_item_o.pos        = pos_q;
    q_item_o.alpha_mode = alpha_q;
    q_item_o.pixel      = {pixel_alpha_i, pixel_blue_i, pixel_green_i, pixel_red_i};
    q_item_o.palette    = (pos_q == FirstPos) ? pal_new : pal_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= FirstPos;
      pal_q   <= '0;
      alpha_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        alpha_q <= cfg_wdata_i;
      end
      if (accept) begin
        pos_q <= pos_d;
        if (pos_q == FirstPos) begin
          pal_q <= pal_new;
        end
      end
    end
  end

endmodule

@@ design/bc1is_back.sv @@
// ----------------------------------------------------------------------------
// bc1is_back: error evaluation and accumulation
// Three stages: squared channel differences, per-entry sums, best-entry
// select; then index and error accumulation into the result queue.
// ----------------------------------------------------------------------------
module bc1is_back
  import bc1is_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  item_t   q_item_i,
  output logic    q_pop_o,
  input  logic    res_full_i,
  output logic    res_push_o,
  output result_t res_o
);

  logic                          advance;
  logic                          s1_valid_q, s2_valid_q, s3_valid_q;
  logic [PosW-1:0]               s1_pos_q, s2_pos_q, s3_pos_q;
  logic [3:0][3:0][SqW-1:0]      s1_sq_q, s1_sq_d;
  logic [3:0][EntryErrW-1:0]     s2_err_q, s2_err_d;
  logic [EntryErrW-1:0]          s3_err_q, best_err;
  logic [1:0]                    s3_idx_q, best_idx;
  logic [IndexW-1:0]             idx_acc_q, idx_acc_d;
  logic [ErrW-1:0]               err_acc_q, err_acc_d;
  logic                          s3_last;

  assign s3_last = (s3_pos_q == LastPos);
  // only a finished block waiting on a full result queue holds the pipe
  assign advance = !(s3_valid_q && s3_last && res_full_i);
  assign q_pop_o = advance && !q_empty_i;

  // stage 1: |pixel - entry|^2 per channel, alpha masked in RGB mode
  always_comb begin
    logic [7:0] p, e, d;
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 4; c++) begin
        p = q_item_i.pixel[c];
        e = q_item_i.palette[k][8*c +: 8];
        d = (p > e) ? p - e : e - p;
        s1_sq_d[k][c] = SqW'(d) * SqW'(d);
        if (c == 3 && !q_item_i.alpha_mode) begin
          s1_sq_d[k][c] = '0;
        end
      end
    end
  end

  // stage 2: per-entry totals
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s2_err_d[k] = EntryErrW'(s1_sq_q[k][0]) + EntryErrW'(s1_sq_q[k][1])
                  + EntryErrW'(s1_sq_q[k][2]) + EntryErrW'(s1_sq_q[k][3]);
    end
  end

  // stage 3: strict less-than keeps the lowest index on ties
  always_comb begin
    best_err = s2_err_q[0];
    best_idx = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (s2_err_q[k] < best_err) begin
        best_err = s2_err_q[k];
        best_idx = 2'(k);
      end
    end
  end

  always_comb begin
    idx_acc_d = idx_acc_q | (IndexW'(s3_idx_q) << {s3_pos_q, 1'b0});
    err_acc_d = err_acc_q + ErrW'(s3_err_q);
  end

  assign res_push_o        = advance && s3_valid_q && s3_last;
  assign res_o.index_word  = idx_acc_d;
  assign res_o.block_error = err_acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      idx_acc_q  <= '0;
      err_acc_q  <= '0;
    end else if (advance) begin
      s1_valid_q <= q_pop_o;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      if (s3_valid_q) begin
        if (s3_last) begin
          idx_acc_q <= '0;
          err_acc_q <= '0;
        end else begin
          idx_acc_q <= idx_acc_d;
          err_acc_q <= err_acc_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_pos_q <= q_item_i.pos;
      s1_sq_q  <= s1_sq_d;
      s2_pos_q <= s1_pos_q;
      s2_err_q <= s2_err_d;
      s3_pos_q <= s2_pos_q;
      s3_err_q <= best_err;
      s3_idx_q <= best_idx;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> (idx_acc_q == '0) && (err_acc_q == '0))
    else $error("accumulators not cleared after block end");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> s3_valid_q && s3_last && $stable(s3_idx_q) && $stable(s3_err_q))
    else $error("stalled last pixel lost");

  a_no_pop_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> advance && !q_empty_i)
    else $error("pop while back end stalled or queue empty");
`endif

endmodule
